// File: design/sdpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpd_pkg
// shared types and constants for the switch debounce and position decoder
// ----------------------------------------------------------------------------
package sdpd_pkg;

  localparam int unsigned NumEvents = 3;

  localparam logic [15:0] DebounceResetMs = 16'd30;

  // contact groups
  localparam logic [7:0] PitotMask = 8'h03;
  localparam logic [7:0] RgenMask  = 8'h0C;
  localparam logic [7:0] LgenMask  = 8'h30;

  // contact bit positions (active low)
  localparam int unsigned PitotOffBit = 0;  // 0x01
  localparam int unsigned PitotOnBit  = 1;  // 0x02
  localparam int unsigned RgenOnBit   = 2;  // 0x04
  localparam int unsigned RgenExtBit  = 3;  // 0x08
  localparam int unsigned LgenOnBit   = 4;  // 0x10
  localparam int unsigned LgenExtBit  = 5;  // 0x20

  // switch identifiers, also the event slot order
  localparam logic [1:0] SwPitot = 2'd0;
  localparam logic [1:0] SwRgen  = 2'd1;
  localparam logic [1:0] SwLgen  = 2'd2;

  // positions
  localparam logic [1:0] PosPitotOff = 2'd0;
  localparam logic [1:0] PosPitotOn  = 2'd1;
  localparam logic [1:0] PosGenOn    = 2'd0;
  localparam logic [1:0] PosGenMid   = 2'd1;
  localparam logic [1:0] PosGenExt   = 2'd2;

  typedef struct packed {
    logic [7:0]  sample;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0] switch_id;
    logic [1:0] position;
    logic       last;
  } out_t;

  // events caused by one poll, one slot per switch
  typedef struct packed {
    logic [NumEvents-1:0]       mask;
    logic [NumEvents-1:0][1:0]  pos;
  } ev_batch_t;

  function automatic logic [1:0] gen_position(input logic on_n, input logic ext_n);
    logic [1:0] p;
    if (!on_n) begin
      p = PosGenOn;
    end else if (!ext_n) begin
      p = PosGenExt;
    end else begin
      p = PosGenMid;
    end
    return p;
  endfunction

endpackage

// File: design/sdpd_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpd_debounce
// debounce state and position decode for one poll per cycle while step_i is high
// ----------------------------------------------------------------------------
module sdpd_debounce (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  sdpd_pkg::in_t      poll_i,
  input  logic [15:0]        debounce_ms_i,
  output sdpd_pkg::ev_batch_t batch_o
);
  import sdpd_pkg::*;

  logic [7:0]  pending_q, pending_d;
  logic [7:0]  stable_q, stable_d;
  logic [31:0] change_q, change_d;
  logic [31:0] elapsed;
  logic        fire;
  logic [7:0]  changed;
  logic [7:0]  s;

  always_comb begin
    if (poll_i.sample != pending_q) begin
      pending_d = poll_i.sample;
      change_d  = poll_i.now_ms;
    end else begin
      pending_d = pending_q;
      change_d  = change_q;
    end
    elapsed  = poll_i.now_ms - change_d;
    fire     = (elapsed >= {16'd0, debounce_ms_i}) && (pending_d != stable_q);
    stable_d = fire ? pending_d : stable_q;
    changed  = fire ? (pending_d ^ stable_q) : 8'd0;
    s        = pending_d;

    // pitot: off wins, neither contact gives nothing
    batch_o.mask[SwPitot] = ((changed & PitotMask) != 8'd0) &&
                            (!s[PitotOffBit] || !s[PitotOnBit]);
    batch_o.pos[SwPitot]  = !s[PitotOffBit] ? PosPitotOff : PosPitotOn;
    batch_o.mask[SwRgen]  = (changed & RgenMask) != 8'd0;
    batch_o.pos[SwRgen]   = gen_position(s[RgenOnBit], s[RgenExtBit]);
    batch_o.mask[SwLgen]  = (changed & LgenMask) != 8'd0;
    batch_o.pos[SwLgen]   = gen_position(s[LgenOnBit], s[LgenExtBit]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      stable_q  <= '0;
      change_q  <= '0;
    end else if (step_i) begin
      pending_q <= pending_d;
      stable_q  <= stable_d;
      change_q  <= change_d;
    end
  end

endmodule

// File: design/sdpd_evbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpd_evbuf
// holds the events of one poll and sends them out one per transfer
// ----------------------------------------------------------------------------
module sdpd_evbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sdpd_pkg::ev_batch_t batch_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sdpd_pkg::out_t      out_data_o
);
  import sdpd_pkg::*;

  logic [NumEvents-1:0]      mask_q, mask_d;
  logic [NumEvents-1:0][1:0] pos_q;
  logic [NumEvents-1:0]      rest;
  logic [1:0]                head;

  assign rest        = mask_q & (mask_q - NumEvents'(1));
  assign out_valid_o = mask_q != '0;
  assign free_o      = (mask_q == '0) || ((rest == '0) && out_ready_i);

  always_comb begin
    priority if (mask_q[SwPitot]) begin
      head = SwPitot;
    end else if (mask_q[SwRgen]) begin
      head = SwRgen;
    end else begin
      head = SwLgen;
    end
    out_data_o.switch_id = head;
    out_data_o.position  = pos_q[head];
    out_data_o.last      = rest == '0;
  end

  always_comb begin
    priority if (load_i) begin
      mask_d = batch_i.mask;
    end else if (out_valid_o && out_ready_i) begin
      mask_d = rest;
    end else begin
      mask_d = mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pos_q <= batch_i.pos;
    end
  end

endmodule

// File: design/switch_debounce_position_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switch_debounce_position_decoder_core
// time-based debouncer for eight active-low contacts with position events
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid_i / in_ready_o / in_data_i): one poll per transfer,
//   an 8-bit contact sample and a free-running millisecond timestamp
//   out channel (out_valid_o / out_ready_i / out_data_o): zero to three
//   position events per poll, pitot heat first, then right and left
//   generator; last marks the final event of a poll
//   cfg_we_i / cfg_data_i: debounce time in ms, written while idle
// timing
//   a poll is held in the input register until the event buffer is free,
//   then is decoded and its events loaded into the buffer, which drives
//   the out channel; the buffer sends one event per cycle while
//   out_ready_i is high and loads the next poll as its last event leaves;
//   event-free polls go one per cycle
// reset
//   debounce time 30 ms, pending, stable and change time all zero,
//   no buffered poll or event
// stall
//   with out_ready_i low the events wait in the buffer; one more poll is
//   held in the input register, after which in_ready_o drops
// ----------------------------------------------------------------------------
module switch_debounce_position_decoder_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sdpd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sdpd_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_data_i
);
  import sdpd_pkg::*;

  // configuration register
  logic [15:0] debounce_q;

  // input register
  logic        in_valid_q;
  in_t         in_data_q;

  ev_batch_t   batch;
  logic        buf_free;
  logic        step;

  // a held poll is decoded as soon as the event buffer can take its events
  assign step       = in_valid_q && buf_free;
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceResetMs;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // state update and event decode for the held poll
  sdpd_debounce u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .poll_i        (in_data_q),
    .debounce_ms_i (debounce_q),
    .batch_o       (batch)
  );

  // event buffer, doubles as the output register
  sdpd_evbuf u_evbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .batch_i     (batch),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
